[hw/rtl/gtp_pkg.sv]
// Shared types, constants and the arctangent table for the go-to-pose controller.
`timescale 1ns / 1ps
package gtp_pkg;

   localparam int CORDIC_STEPS_DEF = 16;

   // datapath widths
   localparam int POS_W   = 32;
   localparam int DIFF_W  = 33;
   localparam int NUM_W   = 2 * DIFF_W;
   localparam int ROOT_W  = DIFF_W;
   localparam int REM_W   = ROOT_W + 2;
   localparam int VEC_W   = 36;
   localparam int Z_W     = 28;
   localparam int ANG_W   = 18;
   localparam int ERR_W   = 19;
   localparam int GAIN_W  = 24;
   localparam int AVEL_W  = 27;

   // angle constants
   localparam logic signed [Z_W-1:0]   PI_Q24     = 28'sd52707179;
   localparam logic signed [ERR_W-1:0] PI_Q13     = 19'sd25736;
   localparam logic signed [ERR_W-1:0] TWO_PI_Q13 = 19'sd51472;

   // register indexes
   localparam logic [3:0] REG_GOAL_X     = 4'd0;
   localparam logic [3:0] REG_GOAL_Y     = 4'd1;
   localparam logic [3:0] REG_GOAL_THETA = 4'd2;
   localparam logic [3:0] REG_DIST_TOL   = 4'd3;
   localparam logic [3:0] REG_ANG_TOL    = 4'd4;
   localparam logic [3:0] REG_LIN_GAIN   = 4'd5;
   localparam logic [3:0] REG_ANG_GAIN   = 4'd6;
   localparam logic [3:0] REG_MAX_LIN    = 4'd7;

   typedef enum logic [2:0] {
      ST_DRIVING   = 3'd0,
      ST_TURNING   = 3'd1,
      ST_REACHED   = 3'd2,
      ST_CANCELLED = 3'd3,
      ST_IDLE      = 3'd4
   } status_type;

   // atan(2^-i) in rad * 2^24, rounded to nearest
   function automatic logic signed [Z_W-1:0] atan_q24(input logic [4:0] idx);
      logic signed [Z_W-1:0] v;
      unique case (idx)
         5'd0:  v = 28'sd13176795;
         5'd1:  v = 28'sd7778716;
         5'd2:  v = 28'sd4110060;
         5'd3:  v = 28'sd2086331;
         5'd4:  v = 28'sd1047214;
         5'd5:  v = 28'sd524117;
         5'd6:  v = 28'sd262123;
         5'd7:  v = 28'sd131069;
         5'd8:  v = 28'sd65536;
         5'd9:  v = 28'sd32768;
         5'd10: v = 28'sd16384;
         5'd11: v = 28'sd8192;
         5'd12: v = 28'sd4096;
         5'd13: v = 28'sd2048;
         5'd14: v = 28'sd1024;
         5'd15: v = 28'sd512;
         5'd16: v = 28'sd256;
         5'd17: v = 28'sd128;
         5'd18: v = 28'sd64;
         5'd19: v = 28'sd32;
         5'd20: v = 28'sd16;
         5'd21: v = 28'sd8;
         5'd22: v = 28'sd4;
         5'd23: v = 28'sd2;
         5'd24: v = 28'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[hw/rtl/go_to_pose_p_controller.sv]
// From accepted pose to result valid: driving runs four serial multiplies and one serial
// root, turning in place runs three multiplies and the root, reached runs two multiplies
// and the root, and idle and cancelled words skip them all; CORDIC runs alongside the multiplies.
// Throughput: one word at a time; the next pose is taken the cycle after the result
// register loads, and a held result stalls the sequencer. Reset is synchronous, active
// high: registers return to their reset values and the goal is active.
`timescale 1ns / 1ps
module go_to_pose_p_controller #(
   parameter int CORDIC_STEPS = gtp_pkg::CORDIC_STEPS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [31:0]  req_pos_x,
   input  logic [31:0]  req_pos_y,
   input  logic [15:0]  req_heading,
   input  logic         req_cancel,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [23:0]  rsp_linear_velocity,
   output logic [26:0]  rsp_angular_velocity,
   output logic [32:0]  rsp_distance_to_goal,
   output logic [2:0]   rsp_status,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [3:0]   csr_index,
   input  logic [31:0]  csr_wdata
);
   localparam int DW = gtp_pkg::DIFF_W;
   localparam int EW = gtp_pkg::ERR_W;

   typedef enum logic [2:0] {
      S_IDLE, S_SQX, S_SQY, S_ROOT, S_DECIDE, S_LIN, S_ANG, S_FIN
   } state_type;

   state_type state_ff;

   // configuration registers
   logic [31:0] goal_x_ff, goal_y_ff;
   logic [15:0] goal_theta_ff;
   logic [30:0] dist_tol_ff;
   logic [14:0] ang_tol_ff;
   logic [23:0] lin_gain_ff, ang_gain_ff, max_lin_ff;
   logic        goal_done_ff;

   // working registers
   logic [DW-1:0]         ay_ff;
   logic signed [15:0]    hd_ff;
   logic [gtp_pkg::NUM_W-1:0] sq_ff;
   logic [DW-1:0]         dist_ff;
   logic [23:0]           lin_ff;
   logic [26:0]           ang_ff;
   logic                  neg_ff;
   logic                  set_done_ff;
   gtp_pkg::status_type   status_ff;

   // result register
   logic        rsp_valid_ff;
   logic [23:0] rsp_lin_ff;
   logic [26:0] rsp_ang_ff;
   logic [32:0] rsp_dist_ff;
   logic [2:0]  rsp_status_ff;

   // unit hookup
   logic                      mul_start, mul_done;
   logic [DW-1:0]             mul_a, mul_b;
   logic [gtp_pkg::NUM_W-1:0] mul_prod;
   logic                      sqrt_start, sqrt_done;
   logic [gtp_pkg::ROOT_W-1:0] sqrt_root;
   logic                      cor_start;
   logic signed [gtp_pkg::ANG_W-1:0] cor_bearing;

   logic signed [DW-1:0] dx_new, dy_new;
   logic [DW-1:0]        ax_new, ay_new;
   logic signed [EW-1:0] berr_raw, berr, ferr_raw, ferr;
   logic [EW-1:0]        berr_mag, ferr_mag;
   logic                 far;
   logic                 req_fire;
   logic                 out_free;
   logic                 goal_wr;
   logic [49:0]          lin_full;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // a goal register write re-arms the goal
   assign goal_wr = csr_valid && csr_ready &&
                    ((csr_index == gtp_pkg::REG_GOAL_X) ||
                     (csr_index == gtp_pkg::REG_GOAL_Y) ||
                     (csr_index == gtp_pkg::REG_GOAL_THETA));

   // goal vector and wrapped angle errors
   always_comb begin
      dx_new = {goal_x_ff[31], goal_x_ff} - {req_pos_x[31], req_pos_x};
      dy_new = {goal_y_ff[31], goal_y_ff} - {req_pos_y[31], req_pos_y};
      ax_new = dx_new[DW-1] ? DW'(-dx_new) : DW'(dx_new);
      ay_new = dy_new[DW-1] ? DW'(-dy_new) : DW'(dy_new);

      berr_raw = EW'(cor_bearing) - EW'(hd_ff);
      if (berr_raw > gtp_pkg::PI_Q13)       berr = berr_raw - gtp_pkg::TWO_PI_Q13;
      else if (berr_raw < -gtp_pkg::PI_Q13) berr = berr_raw + gtp_pkg::TWO_PI_Q13;
      else                                  berr = berr_raw;
      berr_mag = berr[EW-1] ? EW'(-berr) : EW'(berr);

      ferr_raw = EW'($signed(goal_theta_ff)) - EW'(hd_ff);
      if (ferr_raw > gtp_pkg::PI_Q13)       ferr = ferr_raw - gtp_pkg::TWO_PI_Q13;
      else if (ferr_raw < -gtp_pkg::PI_Q13) ferr = ferr_raw + gtp_pkg::TWO_PI_Q13;
      else                                  ferr = ferr_raw;
      ferr_mag = ferr[EW-1] ? EW'(-ferr) : EW'(ferr);

      far      = dist_ff > {2'b00, dist_tol_ff};
      lin_full = mul_prod[65:16];
   end

   // unit starts and operand selection
   always_comb begin
      mul_start  = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      sqrt_start = 1'b0;
      cor_start  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && !goal_done_ff && !req_cancel) begin
               mul_start = 1'b1;
               mul_a     = ax_new;
               mul_b     = ax_new;
               cor_start = 1'b1;
            end
         end
         S_SQX: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_a     = ay_ff;
               mul_b     = ay_ff;
            end
         end
         S_SQY:  sqrt_start = mul_done;
         S_ROOT: ;
         S_DECIDE: begin
            if (far) begin
               mul_start = 1'b1;
               mul_a     = DW'(lin_gain_ff);
               mul_b     = dist_ff;
            end else if (ferr_mag > EW'(ang_tol_ff)) begin
               mul_start = 1'b1;
               mul_a     = DW'(ang_gain_ff);
               mul_b     = DW'(ferr_mag);
            end
         end
         S_LIN: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_a     = DW'(ang_gain_ff);
               mul_b     = DW'(berr_mag);
            end
         end
         S_ANG: ;
         S_FIN: ;
         default: ;
      endcase
   end

   // sequencer, configuration and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         goal_x_ff     <= '0;
         goal_y_ff     <= '0;
         goal_theta_ff <= '0;
         dist_tol_ff   <= 31'd6554;
         ang_tol_ff    <= 15'd819;
         lin_gain_ff   <= 24'd32768;
         ang_gain_ff   <= 24'd65536;
         max_lin_ff    <= 24'd32768;
         goal_done_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         set_done_ff   <= 1'b0;
      end else begin
         // result valid: load from the sequencer, clear on acceptance
         if (state_ff == S_FIN && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;

         // goal done flag
         if (goal_wr) goal_done_ff <= 1'b0;
         else if (state_ff == S_FIN && out_free && set_done_ff) goal_done_ff <= 1'b1;

         if (csr_valid && csr_ready) begin
            priority case (csr_index)
               gtp_pkg::REG_GOAL_X:     goal_x_ff     <= csr_wdata;
               gtp_pkg::REG_GOAL_Y:     goal_y_ff     <= csr_wdata;
               gtp_pkg::REG_GOAL_THETA: goal_theta_ff <= csr_wdata[15:0];
               gtp_pkg::REG_DIST_TOL: dist_tol_ff <= csr_wdata[30:0];
               gtp_pkg::REG_ANG_TOL:  ang_tol_ff  <= csr_wdata[14:0];
               gtp_pkg::REG_LIN_GAIN: lin_gain_ff <= csr_wdata[23:0];
               gtp_pkg::REG_ANG_GAIN: ang_gain_ff <= csr_wdata[23:0];
               gtp_pkg::REG_MAX_LIN:  max_lin_ff  <= csr_wdata[23:0];
               default: ;
            endcase
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  ay_ff       <= ay_new;
                  hd_ff       <= $signed(req_heading);
                  lin_ff      <= '0;
                  ang_ff      <= '0;
                  dist_ff     <= '0;
                  set_done_ff <= 1'b0;
                  if (goal_done_ff) begin
                     status_ff <= gtp_pkg::ST_IDLE;
                     state_ff  <= S_FIN;
                  end else if (req_cancel) begin
                     status_ff   <= gtp_pkg::ST_CANCELLED;
                     set_done_ff <= 1'b1;
                     state_ff    <= S_FIN;
                  end else begin
                     state_ff <= S_SQX;
                  end
               end
            end
            S_SQX: begin
               if (mul_done) begin
                  sq_ff    <= mul_prod;
                  state_ff <= S_SQY;
               end
            end
            S_SQY: begin
               if (mul_done) state_ff <= S_ROOT;
            end
            S_ROOT: begin
               if (sqrt_done) begin
                  dist_ff  <= sqrt_root;
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               if (far) begin
                  status_ff <= gtp_pkg::ST_DRIVING;
                  state_ff  <= S_LIN;
               end else if (ferr_mag > EW'(ang_tol_ff)) begin
                  status_ff <= gtp_pkg::ST_TURNING;
                  neg_ff    <= ferr[EW-1];
                  state_ff  <= S_ANG;
               end else begin
                  status_ff   <= gtp_pkg::ST_REACHED;
                  set_done_ff <= 1'b1;
                  state_ff    <= S_FIN;
               end
            end
            S_LIN: begin
               if (mul_done) begin
                  lin_ff   <= (lin_full > {26'd0, max_lin_ff}) ? max_lin_ff
                                                              : mul_prod[39:16];
                  neg_ff   <= berr[EW-1];
                  state_ff <= S_ANG;
               end
            end
            S_ANG: begin
               if (mul_done) begin
                  ang_ff   <= neg_ff ? 27'(-mul_prod[39:13]) : mul_prod[39:13];
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               if (out_free) begin
                  rsp_lin_ff    <= lin_ff;
                  rsp_ang_ff    <= ang_ff;
                  rsp_dist_ff   <= dist_ff;
                  rsp_status_ff <= status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // sum of squares feeds the root unit
   gtp_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (mul_prod),
      .done  (mul_done)
   );

   gtp_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .num   (sq_ff + mul_prod),
      .root  (sqrt_root),
      .done  (sqrt_done)
   );

   // bearing settles well before the sequencer reaches the decision
   gtp_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .dx      (dx_new),
      .dy      (dy_new),
      .bearing (cor_bearing)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_linear_velocity  = rsp_lin_ff;
   assign rsp_angular_velocity = rsp_ang_ff;
   assign rsp_distance_to_goal = rsp_dist_ff;
   assign rsp_status           = rsp_status_ff;
endmodule

[hw/rtl/gtp_mul.sv]
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module gtp_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [gtp_pkg::DIFF_W-1:0]    a,
   input  logic [gtp_pkg::DIFF_W-1:0]    b,
   output logic [gtp_pkg::NUM_W-1:0]     prod,
   output logic                          done
);
   localparam int W  = gtp_pkg::DIFF_W;
   localparam int CW = $clog2(W + 1);

   logic [2*W:0]   p_ff, p_in;
   logic [W-1:0]   a_ff;
   logic [CW-1:0]  cnt_ff;
   logic           busy_ff;
   logic           done_ff;
   logic [W:0]     hi_add;

   // conditional add of the multiplicand into the upper half
   always_comb begin
      hi_add = p_ff[0] ? (p_ff[2*W:W] + {1'b0, a_ff}) : p_ff[2*W:W];
      p_in   = {1'b0, hi_add, p_ff[W-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // operand and product shift register
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= a;
         p_ff <= {{(W + 1){1'b0}}, b};
      end else if (busy_ff) begin
         p_ff <= p_in;
      end
   end

   assign prod = p_ff[2*W-1:0];
   assign done = done_ff;
endmodule

[hw/rtl/gtp_sqrt.sv]
// Digit-by-digit integer square root, one root bit per cycle.
`timescale 1ns / 1ps
module gtp_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [gtp_pkg::NUM_W-1:0]     num,
   output logic [gtp_pkg::ROOT_W-1:0]    root,
   output logic                          done
);
   localparam int NW = gtp_pkg::NUM_W;
   localparam int RW = gtp_pkg::ROOT_W;
   localparam int MW = gtp_pkg::REM_W;
   localparam int CW = $clog2(RW + 1);

   logic [NW-1:0]  num_ff;
   logic [MW-1:0]  rem_ff;
   logic [RW-1:0]  root_ff;
   logic [CW-1:0]  cnt_ff;
   logic           busy_ff;
   logic           done_ff;
   logic [MW-1:0]  rem_sh, trial;
   logic           fits;

   // bring in the next two radicand bits and try a one
   always_comb begin
      rem_sh = {rem_ff[MW-3:0], num_ff[NW-1:NW-2]};
      trial  = {root_ff, 2'b01};
      fits   = (rem_sh >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(RW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff  <= num;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         num_ff  <= {num_ff[NW-3:0], 2'b00};
         rem_ff  <= fits ? (rem_sh - trial) : rem_sh;
         root_ff <= {root_ff[RW-2:0], fits};
      end
   end

   assign root = root_ff;
   assign done = done_ff;
endmodule

[hw/rtl/gtp_cordic.sv]
// Iterative CORDIC vectoring unit giving the bearing of (dx, dy) in Q3.13.
`timescale 1ns / 1ps
module gtp_cordic #(
   parameter int STEPS = gtp_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [gtp_pkg::DIFF_W-1:0]    dx,
   input  logic signed [gtp_pkg::DIFF_W-1:0]    dy,
   output logic signed [gtp_pkg::ANG_W-1:0]     bearing
);
   localparam int VW = gtp_pkg::VEC_W;
   localparam int ZW = gtp_pkg::Z_W;
   localparam int CW = $clog2(STEPS + 1);

   logic signed [VW-1:0]  x_ff, y_ff, xs, ys;
   logic signed [ZW-1:0]  z_ff, z_rnd;
   logic signed [ZW-1:0]  at;
   logic [CW-1:0]         cnt_ff;
   logic [4:0]            sh;
   logic                  zero_ff;
   logic                  busy_ff;
   logic signed [VW-1:0]  dx_e, dy_e;

   always_comb begin
      dx_e  = VW'(dx);
      dy_e  = VW'(dy);
      sh    = 5'(cnt_ff);
      xs    = x_ff >>> sh;
      ys    = y_ff >>> sh;
      at    = gtp_pkg::atan_q24(sh);
      z_rnd = z_ff + ZW'(1024);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(STEPS - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // quadrant pre-rotation on start, then one micro-rotation per cycle
   always_ff @(posedge clock) begin
      if (start) begin
         zero_ff <= (dx == '0) && (dy == '0);
         if (dx < 0) begin
            x_ff <= -dx_e;
            y_ff <= -dy_e;
            z_ff <= (dy >= 0) ? gtp_pkg::PI_Q24 : -gtp_pkg::PI_Q24;
         end else begin
            x_ff <= dx_e;
            y_ff <= dy_e;
            z_ff <= '0;
         end
      end else if (busy_ff) begin
         if (y_ff >= 0) begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + at;
         end else begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - at;
         end
      end
   end

   assign bearing = zero_ff ? '0 : gtp_pkg::ANG_W'(z_rnd >>> 11);
endmodule

[tb/go_to_pose_p_controller_tb.sv]
// Self-checking testbench for the go-to-pose proportional controller.
`timescale 1ns / 1ps
module go_to_pose_p_controller_tb;

   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 250;
   localparam int RANDOM_WORDS = 1800;

   typedef struct {
      logic [23:0] lin;
      logic [26:0] ang;
      logic [32:0] dist_q;
      gtp_pkg::status_type st;
   } cmd_word_type;

   // Mirrors the controller registers and predicts each command word.
   class pose_scoreboard;
      logic signed [31:0] gx, gy;
      logic [15:0] gtheta;
      logic [30:0] dist_tol;
      logic [14:0] ang_tol;
      logic [23:0] lin_gain, ang_gain, max_lin;
      bit done;
      cmd_word_type pending[$];
      int errors;
      longint atan_lut[16] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                               262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048,
                               1024, 512};

      function new();
         gx = 0; gy = 0; gtheta = 0;
         dist_tol = 6554; ang_tol = 819;
         lin_gain = 32768; ang_gain = 65536; max_lin = 32768;
         done = 0; errors = 0;
      endfunction

      function void write_reg(logic [3:0] idx, logic [31:0] val);
         case (idx)
            gtp_pkg::REG_GOAL_X:     begin gx = val; done = 0; end
            gtp_pkg::REG_GOAL_Y:     begin gy = val; done = 0; end
            gtp_pkg::REG_GOAL_THETA: begin gtheta = val[15:0]; done = 0; end
            gtp_pkg::REG_DIST_TOL:   dist_tol = val[30:0];
            gtp_pkg::REG_ANG_TOL:    ang_tol = val[14:0];
            gtp_pkg::REG_LIN_GAIN:   lin_gain = val[23:0];
            gtp_pkg::REG_ANG_GAIN:   ang_gain = val[23:0];
            gtp_pkg::REG_MAX_LIN:    max_lin = val[23:0];
            default: ;
         endcase
      endfunction

      function longint wrap_angle(longint e);
         while (e > 25736) e -= 51472;
         while (e < -25736) e += 51472;
         return e;
      endfunction

      // CORDIC vectoring in rad*2^24, rounded to Q3.13
      function longint bearing(longint dx, longint dy);
         longint x, y, z, xs, ys;
         x = dx; y = dy; z = 0;
         if (dx == 0 && dy == 0) return 0;
         if (dx < 0) begin
            z = (dy >= 0) ? 64'sd52707179 : -64'sd52707179;
            x = -dx; y = -dy;
         end
         for (int i = 0; i < 16; i++) begin
            xs = x >>> i; ys = y >>> i;
            if (y >= 0) begin x += ys; y -= xs; z += atan_lut[i]; end
            else begin x -= ys; y += xs; z -= atan_lut[i]; end
         end
         return (z + 1024) >>> 11;
      endfunction

      function longint turn_rate(longint err);
         longint mag, v;
         mag = (err < 0) ? -err : err;
         v = (longint'(ang_gain) * mag) >>> 13;
         return (err < 0) ? -v : v;
      endfunction

      function void note_pose(logic signed [31:0] px, logic signed [31:0] py,
                              logic signed [15:0] hd, logic cn);
         cmd_word_type w;
         longint dx, dy, err, lin, ang;
         logic [67:0] ax, ay, num, res, bitv, t;
         w.lin = 0; w.ang = 0; w.dist_q = 0; ang = 0;
         if (done) w.st = gtp_pkg::ST_IDLE;
         else if (cn) begin
            w.st = gtp_pkg::ST_CANCELLED; done = 1;
         end else begin
            dx = longint'(gx) - longint'(px);
            dy = longint'(gy) - longint'(py);
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            num = ax * ax + ay * ay;
            res = 0; bitv = 68'h1 << 66;
            // bitwise integer square root
            while (bitv != 0) begin
               t = res + bitv;
               if (num >= t) begin num -= t; res = (res >> 1) + bitv; end
               else res = res >> 1;
               bitv = bitv >> 2;
            end
            w.dist_q = res[32:0];
            if (res > dist_tol) begin
               err = wrap_angle(bearing(dx, dy) - longint'(hd));
               lin = (longint'(lin_gain) * longint'(res[32:0])) >>> 16;
               if (lin > max_lin) lin = max_lin;
               w.lin = lin[23:0];
               ang = turn_rate(err);
               w.st = gtp_pkg::ST_DRIVING;
            end else begin
               err = wrap_angle(longint'($signed(gtheta)) - longint'(hd));
               if (((err < 0) ? -err : err) > ang_tol) begin
                  ang = turn_rate(err); w.st = gtp_pkg::ST_TURNING;
               end else begin
                  w.st = gtp_pkg::ST_REACHED; done = 1;
               end
            end
            w.ang = ang[26:0];
         end
         pending.push_back(w);
      endfunction

      function void check_cmd(logic [23:0] lin, logic [26:0] ang, logic [32:0] dist_q,
                              logic [2:0] st);
         cmd_word_type w;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected command word st=%0d", st);
            return;
         end
         w = pending.pop_front();
         if (lin !== w.lin || ang !== w.ang || dist_q !== w.dist_q || st !== w.st) begin
            errors++;
            if (errors <= 10)
               $display({"mismatch: exp lin=%0d ang=%0d dist=%0d st=%0d, ",
                         "got lin=%0d ang=%0d dist=%0d st=%0d"},
                        w.lin, $signed(w.ang), w.dist_q, w.st,
                        lin, $signed(ang), dist_q, st);
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_ready, req_cancel;
   logic [31:0] req_pos_x, req_pos_y;
   logic [15:0] req_heading;
   logic rsp_valid, rsp_ready;
   logic [23:0] rsp_linear_velocity;
   logic [26:0] rsp_angular_velocity;
   logic [32:0] rsp_distance_to_goal;
   logic [2:0] rsp_status;
   logic csr_valid, csr_ready;
   logic [3:0] csr_index;
   logic [31:0] csr_wdata;

   pose_scoreboard sb = new();
   bit gaps_on = 1;
   int quiet_cycles = 0;

   go_to_pose_p_controller i_dut (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // random gap length: mostly short, a few long
   function automatic int gap_len();
      if (!gaps_on) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
   endfunction

   // result side back-pressure
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= 1;
         if (rsp_valid && rsp_ready) stall_left <= gap_len();
      end
   end

   // monitor: sees pre-edge values, feeds the scoreboard, runs the watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_pose(req_pos_x, req_pos_y, req_heading, req_cancel);
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_wdata);
         if (rsp_valid && rsp_ready)
            sb.check_cmd(rsp_linear_velocity, rsp_angular_velocity,
                         rsp_distance_to_goal, rsp_status);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
               $display("go_to_pose_p_controller_tb NOT OK");
               $finish;
            end
         end
      end
   end

   // valid stays up across back-to-back words; this task drops it only for a gap
   task automatic send_pose(logic [31:0] px, logic [31:0] py, logic [15:0] hd, logic cn);
      int g;
      g = gap_len();
      csr_valid <= 0;
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1; req_pos_x <= px; req_pos_y <= py;
      req_heading <= hd; req_cancel <= cn;
      // ready is stable from the falling edge to the accepting edge
      do begin
         @(negedge clock);
      end while (!req_ready);
      @(posedge clock);
   endtask

   task automatic write_csr(logic [3:0] idx, logic [31:0] val);
      req_valid <= 0;
      csr_valid <= 1; csr_index <= idx; csr_wdata <= val;
      do begin
         @(negedge clock);
      end while (!csr_ready);
      @(posedge clock);
   endtask

   // drop both valids, then wait until every accepted word has come back
   task automatic wait_drained();
      req_valid <= 0;
      csr_valid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_extreme(logic [31:0] hi);
      case ($urandom_range(0, 5))
         0: return 0;
         1: return hi;
         2: return $urandom_range(0, 4) & hi;
         default: return $urandom & hi;
      endcase
   endfunction

   // offset of random scale so poses land around the tolerances
   function automatic logic [31:0] near(logic [31:0] c);
      int k;
      logic [31:0] off;
      k = $urandom_range(0, 22);
      off = $urandom & ((32'h1 << k) - 1);
      return $urandom_range(0, 1) ? c + off : c - off;
   endfunction

   initial begin
      logic [31:0] px, py;
      logic [15:0] hd;
      int n;
      reset <= 1; req_valid <= 0; req_pos_x <= 0; req_pos_y <= 0;
      req_heading <= 0; req_cancel <= 0; csr_valid <= 0; csr_index <= 0; csr_wdata <= 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset goal, at origin -> reached, then idle
      send_pose(0, 0, 0, 0);
      send_pose(0, 0, 0, 1);
      wait_drained();
      write_csr(gtp_pkg::REG_GOAL_X, 32'd10 << 16);
      send_pose(0, 0, 0, 0);
      send_pose(32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF, 0);
      send_pose(32'h7FFF_FFFF, 32'h8000_0000, 16'h8000, 0);
      send_pose(32'd20 << 16, 0, 16'd25736, 0);
      send_pose(32'd20 << 16, 32'd1, -16'sd25736, 0);
      send_pose(32'd20 << 16, -32'sd1, 16'd0, 0);
      wait_drained();
      write_csr(gtp_pkg::REG_GOAL_THETA, 32'd25736);
      write_csr(gtp_pkg::REG_LIN_GAIN, 32'hFF_FFFF);
      write_csr(gtp_pkg::REG_ANG_GAIN, 32'hFF_FFFF);
      write_csr(gtp_pkg::REG_MAX_LIN, 32'hFF_FFFF);
      send_pose(32'd10 << 16, 0, -16'sd25736, 0);
      send_pose(32'd10 << 16, 0, 16'h7FFF, 0);
      send_pose(32'd10 << 16, 1, 16'h8000, 0);
      send_pose(32'h8000_0000, 32'h8000_0000, 16'd0, 0);
      send_pose(32'd10 << 16, 0, 16'd25736, 0);
      send_pose(0, 0, 0, 1);
      wait_drained();
      write_csr(gtp_pkg::REG_GOAL_Y, 32'h7FFF_FFFF);
      write_csr(gtp_pkg::REG_GOAL_X, 32'h7FFF_FFFF);
      write_csr(gtp_pkg::REG_DIST_TOL, 32'hFFFF_FFFF);
      write_csr(gtp_pkg::REG_ANG_TOL, 32'h0);
      write_csr(4'd9, 32'h1234);
      send_pose(32'h8000_0000, 32'h8000_0000, 16'd100, 0);
      send_pose(32'h8000_0000, 32'h8000_0000, 16'd0, 1);
      wait_drained();
      write_csr(gtp_pkg::REG_DIST_TOL, 0);
      write_csr(gtp_pkg::REG_ANG_TOL, 32'hFFFF);
      write_csr(gtp_pkg::REG_LIN_GAIN, 0);
      write_csr(gtp_pkg::REG_ANG_GAIN, 0);
      write_csr(gtp_pkg::REG_MAX_LIN, 0);
      write_csr(gtp_pkg::REG_GOAL_THETA, 32'hFFFF);
      send_pose(32'h8000_0000, 0, 16'd3, 0);
      send_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd3, 0);
      wait_drained();

      // random phases, each with a fresh goal and some register changes
      n = 0;
      while (n < RANDOM_WORDS) begin
         gaps_on = ($urandom_range(0, 4) != 0);
         wait_drained();
         if ($urandom_range(0, 2) == 0)
            write_csr(gtp_pkg::REG_DIST_TOL,
                      pick_extreme(32'h7FFF_FFFF) >> $urandom_range(0, 14));
         if ($urandom_range(0, 2) == 0)
            write_csr(gtp_pkg::REG_ANG_TOL, pick_extreme(32'h7FFF) % 25737);
         if ($urandom_range(0, 2) == 0)
            write_csr(gtp_pkg::REG_LIN_GAIN, pick_extreme(32'hFF_FFFF));
         if ($urandom_range(0, 2) == 0)
            write_csr(gtp_pkg::REG_ANG_GAIN, pick_extreme(32'hFF_FFFF));
         if ($urandom_range(0, 2) == 0)
            write_csr(gtp_pkg::REG_MAX_LIN, pick_extreme(32'hFF_FFFF));
         if ($urandom_range(0, 9) == 0) write_csr(4'($urandom_range(8, 15)), $urandom);
         write_csr(gtp_pkg::REG_GOAL_X, $urandom_range(0, 3) == 0 ? pick_extreme(32'hFFFF_FFFF)
                                                                  : $urandom);
         if ($urandom_range(0, 3) != 0) write_csr(gtp_pkg::REG_GOAL_Y, $urandom);
         if ($urandom_range(0, 1) == 0)
            write_csr(gtp_pkg::REG_GOAL_THETA,
                      $urandom_range(0, 7) == 0 ? $urandom
                                                : $urandom_range(0, 51472) - 25736);
         repeat ($urandom_range(5, 40)) begin
            case ($urandom_range(0, 9))
               0: begin px = $urandom; py = $urandom; end
               1, 2: begin px = sb.gx; py = sb.gy; end
               default: begin px = near(sb.gx); py = near(sb.gy); end
            endcase
            case ($urandom_range(0, 4))
               0: hd = 16'($urandom);
               1, 2: hd = 16'(sb.gtheta + $urandom_range(0, 2000) - 1000);
               default: hd = 16'($urandom_range(0, 51472) - 25736);
            endcase
            send_pose(px, py, hd, $urandom_range(0, 24) == 0);
            n++;
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("go_to_pose_p_controller_tb OK");
      else
         $display("go_to_pose_p_controller_tb NOT OK");
      $finish;
   end
endmodule
